@@ hdl/tlnc_pkg.sv @@
// Package for the text line number and caret filter.
// Holds character codes, counter sizes, the config register indexes and BCD helpers.
// No dependencies.
package tlnc_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int BCD_W         = 4 * NUMBER_DIGITS;
  localparam int MAX_RESULTS   = NUMBER_DIGITS + 3;
  localparam int IDX_W         = $clog2(MAX_RESULTS);
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
  localparam int CFG_IDX_W     = 3;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DOLL  = 8'd36;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_I     = 8'd73;
  localparam logic [7:0] CH_CARET = 8'd94;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CARET_OFFS = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_NONBLANK  = 3'd0,
    CFG_NUMBER_ALL       = 3'd1,
    CFG_SQUEEZE_BLANK    = 3'd2,
    CFG_SHOW_TABS        = 3'd3,
    CFG_SHOW_ENDS        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_idx_t;

  typedef logic [BCD_W-1:0] bcd_t;

  // Decimal increment that sticks at all nines
  function automatic bcd_t bcd_bump(input bcd_t v);
    bcd_t       r;
    logic       carry;
    logic       all_nines;
    logic [3:0] d;
    r         = v;
    carry     = 1'b1;
    all_nines = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = v[4*i +: 4];
      if (d != 4'd9) all_nines = 1'b0;
      if (carry) begin
        if (d >= 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = d + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    if (all_nines) r = v;
    return r;
  endfunction

endpackage

@@ hdl/text_line_number_and_caret_filter_top.sv @@
// Top level of the text line number and caret filter.
// Depends on tlnc_pkg.
//
// Takes one text byte per transaction and emits the formatted bytes it causes,
// with last marking the final one. Each accepted byte is fully processed in the
// cycle it is taken: line state and the BCD counters update at once and the
// results land in a small result buffer, which drains one byte per cycle while
// out_ready is high. Bytes giving a single result therefore stream at full rate
// while out_ready holds; a byte giving n results (up to NUMBER_DIGITS+3 = 9 at a
// numbered line start, 2 for a caret or $ form) holds the input until its results
// have drained, the drain of the result buffer being what sets the rate.
// A squeezed blank line gives no result. A new byte is taken in the same
// cycle the last buffered byte leaves. Its first result is out in the next cycle.
module text_line_number_and_caret_filter_top
  import tlnc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_new_file,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  logic number_nonblank_r, number_all_r, squeeze_blank_r;
  logic show_tabs_r, show_ends_r, show_nonprinting_r;

  logic       at_line_start_r, at_line_start_nxt;
  logic [1:0] blank_run_r, blank_run_nxt;
  bcd_t       nonblank_count_r, nonblank_count_nxt;
  bcd_t       line_count_r, line_count_nxt;

  logic [7:0]       res_buf_r [MAX_RESULTS];
  logic [7:0]       res_buf_nxt [MAX_RESULTS];
  logic [CNT_W-1:0] rem_r, cnt_nxt;
  logic [IDX_W-1:0] rd_idx_r;

  logic       in_acc, out_acc;
  logic       blank, drop, numbered, two;
  bcd_t       num_val;
  logic [7:0] body_a, body_b;
  logic [7:0] num_ch [NUMBER_DIGITS];
  logic       lead;
  logic [CNT_W-1:0] base;

  assign out_valid = (rem_r != '0);
  assign out_acc   = out_valid && out_ready;
  assign in_ready  = (rem_r == '0) || ((rem_r == CNT_W'(1)) && out_ready);
  assign in_acc    = in_valid && in_ready;
  assign out_byte  = res_buf_r[rd_idx_r];
  assign out_last  = (rem_r == CNT_W'(1));

  // Line state, counters and result bytes for the byte on the input
  always_comb begin
    nonblank_count_nxt = in_new_file ? '0 : nonblank_count_r;
    line_count_nxt     = in_new_file ? '0 : line_count_r;
    at_line_start_nxt  = in_new_file | at_line_start_r;
    blank_run_nxt      = blank_run_r;
    blank    = (in_data_byte == CH_LF);
    drop     = 1'b0;
    numbered = 1'b0;
    num_val  = '0;

    if (at_line_start_nxt) begin
      if (squeeze_blank_r) begin
        if (blank) begin
          if (blank_run_r < 2'd2) blank_run_nxt = blank_run_r + 2'd1;
        end else begin
          blank_run_nxt = 2'd0;
        end
        if (blank_run_nxt > 2'd1) drop = 1'b1;
      end
      if (!drop) begin
        if (number_nonblank_r) begin
          if (!blank) begin
            nonblank_count_nxt = bcd_bump(nonblank_count_nxt);
            numbered           = 1'b1;
            num_val            = nonblank_count_nxt;
          end
        end else if (number_all_r) begin
          line_count_nxt = bcd_bump(line_count_nxt);
          numbered       = 1'b1;
          num_val        = line_count_nxt;
        end
        at_line_start_nxt = 1'b0;
      end
    end
    if (!drop && blank) at_line_start_nxt = 1'b1;

    two    = 1'b1;
    body_b = in_data_byte;
    if (show_tabs_r && in_data_byte == CH_TAB) begin
      body_a = CH_CARET;
      body_b = CH_I;
    end else if (show_ends_r && blank) begin
      body_a = CH_DOLL;
      body_b = CH_LF;
    end else if (show_nonprinting_r &&
                 (in_data_byte < CH_TAB ||
                  (in_data_byte > CH_LF && in_data_byte < CH_SPACE) ||
                  in_data_byte == CH_DEL)) begin
      body_a = CH_CARET;
      body_b = (in_data_byte == CH_DEL) ? in_data_byte - CARET_OFFS
                                        : in_data_byte + CARET_OFFS;
    end else begin
      body_a = in_data_byte;
      two    = 1'b0;
    end

    // Leading zeros become spaces; the units digit always shows
    lead = 1'b1;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      if (num_val[4*i +: 4] != 4'd0 || i == 0) lead = 1'b0;
      num_ch[NUMBER_DIGITS-1-i] = lead ? CH_SPACE : (CH_ZERO + {4'd0, num_val[4*i +: 4]});
    end

    base = numbered ? CNT_W'(NUMBER_DIGITS + 1) : '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (numbered && k < NUMBER_DIGITS) begin
        res_buf_nxt[k] = num_ch[k];
      end else if (numbered && k == NUMBER_DIGITS) begin
        res_buf_nxt[k] = CH_TAB;
      end else if (CNT_W'(k) == base) begin
        res_buf_nxt[k] = body_a;
      end else begin
        res_buf_nxt[k] = body_b;
      end
    end

    if (drop) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = base + (two ? CNT_W'(2) : CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_nonblank_r  <= 1'b0;
      number_all_r       <= 1'b0;
      squeeze_blank_r    <= 1'b0;
      show_tabs_r        <= 1'b0;
      show_ends_r        <= 1'b0;
      show_nonprinting_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NUMBER_NONBLANK:  number_nonblank_r  <= cfg_data;
        CFG_NUMBER_ALL:       number_all_r       <= cfg_data;
        CFG_SQUEEZE_BLANK:    squeeze_blank_r    <= cfg_data;
        CFG_SHOW_TABS:        show_tabs_r        <= cfg_data;
        CFG_SHOW_ENDS:        show_ends_r        <= cfg_data;
        CFG_SHOW_NONPRINTING: show_nonprinting_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r  <= 1'b1;
      blank_run_r      <= 2'd0;
      nonblank_count_r <= '0;
      line_count_r     <= '0;
      rem_r            <= '0;
      rd_idx_r         <= '0;
    end else if (in_acc) begin
      at_line_start_r  <= at_line_start_nxt;
      blank_run_r      <= blank_run_nxt;
      nonblank_count_r <= nonblank_count_nxt;
      line_count_r     <= line_count_nxt;
      rem_r            <= cnt_nxt;
      rd_idx_r         <= '0;
    end else if (out_acc) begin
      rem_r    <= rem_r - CNT_W'(1);
      rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < MAX_RESULTS; k++) res_buf_r[k] <= res_buf_nxt[k];
    end
  end

endmodule
